// ----- sv/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment display driver package
// Request and result codes, the queue word types and the segment table.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Request codes on req_type.
	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_RAW   = 3'd1;
	localparam logic [2:0] REQ_DIGIT = 3'd2;
	localparam logic [2:0] REQ_SHOW  = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;
	localparam logic [2:0] REQ_READ  = 3'd5;

	// Operation codes passed from the front to the back.
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_SHOW  = 3'd2;
	localparam logic [2:0] OP_CLEAR = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// Result kinds on out_kind.
	localparam logic [1:0] KIND_BIT   = 2'd0;
	localparam logic [1:0] KIND_LATCH = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Reciprocal of ten, scaled by 2^19, exact for all 16-bit values.
	localparam logic [15:0] RECIP_TEN = 16'd52429;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  pos;
		logic        pos_ok;
		logic [7:0]  data;
		logic [15:0] number;
		logic        lead;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       bit_val;
		logic [3:0] mask;
		logic [7:0] rd;
		logic       last;
	} res_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'b0011_1111;
			4'd1: s = 8'b0000_0110;
			4'd2: s = 8'b0101_1011;
			4'd3: s = 8'b0100_1111;
			4'd4: s = 8'b0110_0110;
			4'd5: s = 8'b0110_1101;
			4'd6: s = 8'b0111_1101;
			4'd7: s = 8'b0010_0111;
			4'd8: s = 8'b0111_1111;
			4'd9: s = 8'b0110_1111;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ----- sv/ssd_front.sv -----
// ----------------------------------------------------------------------------
// Seven-segment driver front end
// Accepts requests, turns them into operations and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module ssd_front #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    req_type,
	input  logic [1:0]    position,
	input  logic [7:0]    raw_value,
	input  logic [3:0]    digit_value,
	input  logic [15:0]   number,
	input  logic          show_leading_zeros,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output ssd_pkg::cmd_t cmd
);
	import ssd_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       keep;
	logic       enq;
	logic       deq;

	always_comb begin
		cls.pos    = position;
		cls.pos_ok = (32'(position) < DIGIT_COUNT);
		cls.data   = raw_value;
		cls.number = number;
		cls.lead   = show_leading_zeros;
		cls.op     = OP_TICK;
		keep       = 1'b1;
		case (req_type)
			REQ_TICK: cls.op = OP_TICK;
			REQ_RAW: begin
				cls.op = OP_WRITE;
				keep   = cls.pos_ok;
			end
			REQ_DIGIT: begin
				cls.op   = OP_WRITE;
				cls.data = seg_of(digit_value);
				keep     = cls.pos_ok;
			end
			REQ_SHOW:  cls.op = OP_SHOW;
			REQ_CLEAR: cls.op = OP_CLEAR;
			REQ_READ:  cls.op = OP_READ;
			default:   keep = 1'b0;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_ptr_q];
	assign enq       = push && !full && keep;
	assign deq       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (enq) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

endmodule

// ----- sv/ssd_res_fifo.sv -----
// ----------------------------------------------------------------------------
// Seven-segment driver result queue
// Two-entry queue of result words between the back end and the output port.
// ----------------------------------------------------------------------------
module ssd_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ssd_pkg::res_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output ssd_pkg::res_t rd_data,
	output logic          empty
);
	import ssd_pkg::*;

	res_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       enq;
	logic       deq;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = buf_q[rd_ptr_q];
	assign enq     = wr_en && !full;
	assign deq     = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (enq) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

endmodule

// ----- sv/ssd_back.sv -----
// ----------------------------------------------------------------------------
// Seven-segment driver back end
// Holds the segment store and scan index, carries out one operation at a
// time and writes the result words into the result queue.
// ----------------------------------------------------------------------------
module ssd_back #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enable,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ssd_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_full,
	output ssd_pkg::res_t res
);
	import ssd_pkg::*;

	localparam int IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int WW = IW + 3;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHOW  = 3'd1;
	localparam logic [2:0] ST_BITS  = 3'd2;
	localparam logic [2:0] ST_LATCH = 3'd3;
	localparam logic [2:0] ST_REPLY = 3'd4;

	logic [7:0]             mem [DIGIT_COUNT];
	logic [DIGIT_COUNT-1:0] valid_q;
	logic [2:0]             state_q;
	logic [2:0]             state_d;
	logic [IW-1:0]          scan_q;
	logic [IW-1:0]          k_q;
	logic [3:0]             mask_q;
	logic [2:0]             cnt_q;
	logic [15:0]            num_q;
	logic                   lead_q;
	logic                   pos_ok_q;
	logic [7:0]             mem_rd_q;
	logic                   rd_vld_q;

	logic                   take;
	logic [IW-1:0]          pos_idx;
	logic [IW-1:0]          scan_nxt;
	logic [WW-1:0]          scan_wide;
	logic [3:0]             mask_nxt;
	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	logic [7:0]             wr_data;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic                   clear_all;
	logic [7:0]             eff;
	logic [31:0]            prod;
	logic [15:0]            quo;
	logic [15:0]            rem;
	logic                   blank;

	assign pos_idx   = IW'((IW + 2)'(cmd.pos));
	assign scan_nxt  = (scan_q == IW'(DIGIT_COUNT - 1)) ? '0 : scan_q + 1'b1;
	assign scan_wide = WW'(scan_nxt);
	// Digits beyond the fourth have no enable line, so their mask is zero.
	assign mask_nxt  = (scan_wide < WW'(4)) ? (4'd1 << scan_wide[1:0]) : 4'd0;
	assign eff       = (rd_vld_q && pos_ok_q) ? mem_rd_q : 8'h00;

	// One decimal digit per cycle: quotient by reciprocal multiply.
	assign prod  = num_q * RECIP_TEN;
	assign quo   = 16'(prod[31:19]);
	assign rem   = num_q - ((quo << 3) + (quo << 1));
	assign blank = !lead_q && (num_q == 16'd0) && (k_q != '0);

	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;

	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		wr_addr   = pos_idx;
		wr_data   = cmd.data;
		rd_en     = 1'b0;
		rd_addr   = pos_idx;
		clear_all = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (cmd.op)
						OP_WRITE: wr_en = cmd.pos_ok;
						OP_CLEAR: clear_all = 1'b1;
						OP_SHOW:  state_d = ST_SHOW;
						OP_READ: begin
							rd_en   = 1'b1;
							state_d = ST_REPLY;
						end
						OP_TICK: begin
							if (enable) begin
								rd_en   = 1'b1;
								rd_addr = scan_nxt;
								state_d = ST_BITS;
							end else begin
								state_d = ST_LATCH;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SHOW: begin
				wr_en   = 1'b1;
				wr_addr = IW'(DIGIT_COUNT - 1) - k_q;
				wr_data = blank ? 8'h00 : seg_of(rem[3:0]);
				if (k_q == IW'(DIGIT_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_BITS: begin
				res_valid   = 1'b1;
				res.kind    = KIND_BIT;
				res.bit_val = eff[3'd7 - cnt_q];
				if (!res_full && cnt_q == 3'd7) begin
					state_d = ST_LATCH;
				end
			end
			ST_LATCH: begin
				res_valid = 1'b1;
				res.kind  = KIND_LATCH;
				res.mask  = mask_q;
				res.last  = 1'b1;
				if (!res_full) begin
					state_d = ST_IDLE;
				end
			end
			ST_REPLY: begin
				res_valid = 1'b1;
				res.kind  = KIND_READ;
				res.rd    = eff;
				res.last  = 1'b1;
				if (!res_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// An entry that was never written since reset or clear reads as blank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clear_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scan_q   <= '0;
			k_q      <= '0;
			mask_q   <= 4'd0;
			cnt_q    <= 3'd0;
			pos_ok_q <= 1'b0;
			num_q    <= 16'd0;
			lead_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					k_q      <= '0;
					cnt_q    <= 3'd0;
					num_q    <= cmd.number;
					lead_q   <= cmd.lead;
					pos_ok_q <= cmd.pos_ok;
					if (take && cmd.op == OP_TICK) begin
						scan_q   <= scan_nxt;
						mask_q   <= enable ? mask_nxt : 4'd0;
						pos_ok_q <= 1'b1;
					end
				end
				ST_SHOW: begin
					k_q   <= k_q + 1'b1;
					num_q <= quo;
				end
				ST_BITS: begin
					if (!res_full) begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/seven_segment_mux_driver_core.sv -----
// ----------------------------------------------------------------------------
// Multiplexed seven-segment display driver
// Keeps one segment byte per digit, scans the digits on refresh ticks and
// shifts each digit's byte out serially while enabled, then a latch word.
// ----------------------------------------------------------------------------
// A request passes through the front queue to the back end; writes and
// clear finish in the cycle the back end takes them. An enabled tick gives
// its nine words, eight segment bits and a latch word, one per cycle unless
// the result queue is full; a disabled tick gives only the latch word. The
// back end works on one request at a time; that sets the rate. Reset: all
// digits blank, scan index zero, display enabled, queues empty.
module seven_segment_mux_driver_core #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic [1:0]  position,
	input  logic [7:0]  raw_value,
	input  logic [3:0]  digit_value,
	input  logic [15:0] number,
	input  logic        show_leading_zeros,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  out_kind,
	output logic        serial_bit,
	output logic [3:0]  digit_mask,
	output logic [7:0]  read_value,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import ssd_pkg::*;

	logic enable_q;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_full;
	res_t res_in;
	res_t res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	ssd_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.req_type          (req_type),
		.position          (position),
		.raw_value         (raw_value),
		.digit_value       (digit_value),
		.number            (number),
		.show_leading_zeros(show_leading_zeros),
		.cmd_valid         (cmd_valid),
		.cmd_ready         (cmd_ready),
		.cmd               (cmd)
	);

	ssd_back #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (enable_q),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_full (res_full),
		.res      (res_in)
	);

	ssd_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign out_kind   = res_out.kind;
	assign serial_bit = res_out.bit_val;
	assign digit_mask = res_out.mask;
	assign read_value = res_out.rd;
	assign last       = res_out.last;

endmodule
